>>> design/tcrt_pkg.sv
// Package for the three-channel reload timer.
// Holds the command codes, register map constants, transaction types and the divider mask.
// No dependencies.
package tcrt_pkg;

  localparam int CHANNELS_DEFAULT = 3;
  localparam int CTL_W            = 10;
  localparam int PRESCALE_W       = 10;
  localparam int IRQ_W            = 3;

  localparam int UNDERFLOW_BIT = 8;
  localparam int ENABLE_BIT    = 5;

  localparam logic [CTL_W-1:0] CTL_MASK_LAST  = 10'h3ff;
  localparam logic [CTL_W-1:0] CTL_MASK_OTHER = 10'h13f;

  localparam logic [3:0] REG_OUT_CTL = 4'd0;
  localparam logic [3:0] REG_START   = 4'd1;
  localparam int         REG_CH_BASE = 2;
  localparam int         REGS_PER_CH = 3;

  localparam logic [2:0] MODE_LAST_VALID = 3'd4;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  reg_index;
    logic [31:0] wdata;
  } req_t;

  function automatic logic [PRESCALE_W-1:0] div_mask(input logic [2:0] mode);
    logic [PRESCALE_W-1:0] m;
    case (mode)
      3'd0:    m = 10'h003;
      3'd1:    m = 10'h00f;
      3'd2:    m = 10'h03f;
      3'd3:    m = 10'h0ff;
      default: m = 10'h3ff;
    endcase
    return m;
  endfunction

endpackage

>>> design/tcrt_if.sv
// Handshake interfaces for the request and response channels of the reload timer.
// Depends on nothing; widths follow the transaction fields.
interface tcrt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, output cmd, output reg_index, output wdata, input ready);
  modport sink   (input valid, input cmd, input reg_index, input wdata, output ready);
endinterface

interface tcrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic [2:0]  irq;

  modport source (output valid, output rdata, output irq, input ready);
  modport sink   (input valid, input rdata, input irq, output ready);
endinterface

>>> design/three_channel_reload_timer.sv
// Three-channel reload timer: CHANNELS (default three) 32-bit down-counters behind word registers.
// Depends on tcrt_pkg and the interfaces in tcrt_if.sv.
//
// Usage:
//   req carries one transaction per item: cmd 0 is a peripheral-clock tick,
//   1 a register read, 2 a register write (reg_index, wdata). Every accepted
//   item yields exactly one transaction on rsp: rdata (read data, else zero)
//   and irq (underflow flag AND interrupt enable per channel, after the item).
//   An accepted item passes the input register and then the result register
//   before its rsp handshake. Throughput is one item per cycle while rsp does
//   not stall; every item completes in the single execute step between those
//   registers.
//   When rsp stalls, the result register holds and the input register still
//   takes one more item; req.ready drops only when both are full.
//   Reset clears the counters and reload values to all ones, control words,
//   dividers, run bits, output control and prescaler to zero, and empties
//   both registers.
module three_channel_reload_timer
  import tcrt_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  tcrt_req_if.sink      req,
  tcrt_rsp_if.source    rsp
);

  localparam int IRQ_N = (CHANNELS < IRQ_W) ? CHANNELS : IRQ_W;

  logic                  in_valid;
  req_t                  in_item;
  logic                  exec;

  logic                  out_valid;
  logic [31:0]           out_rdata;
  logic [IRQ_W-1:0]      out_irq;

  logic [31:0]           count       [CHANNELS];
  logic [31:0]           reload      [CHANNELS];
  logic [CTL_W-1:0]      ctl         [CHANNELS];
  logic [2:0]            mode        [CHANNELS];
  logic [CHANNELS-1:0]   run;
  logic                  out_ctl;
  logic [PRESCALE_W-1:0] prescale;

  logic [31:0]           count_next  [CHANNELS];
  logic [31:0]           reload_next [CHANNELS];
  logic [CTL_W-1:0]      ctl_next    [CHANNELS];
  logic [2:0]            mode_next   [CHANNELS];
  logic [CHANNELS-1:0]   run_next;
  logic                  out_ctl_next;
  logic [PRESCALE_W-1:0] prescale_next;
  logic [31:0]           rdata_next;
  logic [IRQ_W-1:0]      irq_next;

  logic [PRESCALE_W-1:0] tick_prescale;
  logic [31:0]           idx;
  logic [CTL_W-1:0]      ctl_wr;

  assign exec      = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || exec;

  assign rsp.valid = out_valid;
  assign rsp.rdata = out_rdata;
  assign rsp.irq   = out_irq;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      in_item.cmd       <= req.cmd;
      in_item.reg_index <= req.reg_index;
      in_item.wdata     <= req.wdata;
    end
  end

  always_comb begin
    count_next    = count;
    reload_next   = reload;
    ctl_next      = ctl;
    mode_next     = mode;
    run_next      = run;
    out_ctl_next  = out_ctl;
    prescale_next = prescale;
    rdata_next    = '0;
    tick_prescale = prescale + 10'd1;
    idx           = 32'(in_item.reg_index);
    ctl_wr        = '0;
    case (in_item.cmd)
      CMD_TICK: begin
        prescale_next = tick_prescale;
        for (int n = 0; n < CHANNELS; n++) begin
          if (run[n] && ((tick_prescale & div_mask(mode[n])) == '0)) begin
            if (count[n] == '0) begin
              count_next[n]              = reload[n];
              ctl_next[n][UNDERFLOW_BIT] = 1'b1;
            end else begin
              count_next[n] = count[n] - 32'd1;
            end
          end
        end
      end
      CMD_READ: begin
        if (in_item.reg_index == REG_OUT_CTL) begin
          rdata_next = {31'd0, out_ctl};
        end else if (in_item.reg_index == REG_START) begin
          rdata_next = 32'(run);
        end
        for (int n = 0; n < CHANNELS; n++) begin
          if (idx == 32'(REG_CH_BASE + REGS_PER_CH * n)) begin
            rdata_next = reload[n];
          end else if (idx == 32'(REG_CH_BASE + REGS_PER_CH * n + 1)) begin
            rdata_next = count[n];
          end else if (idx == 32'(REG_CH_BASE + REGS_PER_CH * n + 2)) begin
            rdata_next = 32'(ctl[n]);
          end
        end
      end
      CMD_WRITE: begin
        if (in_item.reg_index == REG_OUT_CTL) begin
          out_ctl_next = in_item.wdata[0];
        end else if (in_item.reg_index == REG_START) begin
          run_next = in_item.wdata[CHANNELS-1:0];
        end
        for (int n = 0; n < CHANNELS; n++) begin
          if (idx == 32'(REG_CH_BASE + REGS_PER_CH * n)) begin
            reload_next[n] = in_item.wdata;
          end else if (idx == 32'(REG_CH_BASE + REGS_PER_CH * n + 1)) begin
            count_next[n] = in_item.wdata;
          end else if (idx == 32'(REG_CH_BASE + REGS_PER_CH * n + 2)) begin
            ctl_wr      = in_item.wdata[CTL_W-1:0]
                          & ((n == CHANNELS - 1) ? CTL_MASK_LAST : CTL_MASK_OTHER);
            ctl_next[n] = ctl_wr;
            if (ctl_wr[2:0] inside {[3'd0:MODE_LAST_VALID]}) begin
              mode_next[n] = ctl_wr[2:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
    irq_next = '0;
    for (int b = 0; b < IRQ_N; b++) begin
      irq_next[b] = ctl_next[b][UNDERFLOW_BIT] && ctl_next[b][ENABLE_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < CHANNELS; n++) begin
        count[n]  <= '1;
        reload[n] <= '1;
        ctl[n]    <= '0;
        mode[n]   <= '0;
      end
      run      <= '0;
      out_ctl  <= 1'b0;
      prescale <= '0;
    end else if (exec) begin
      count    <= count_next;
      reload   <= reload_next;
      ctl      <= ctl_next;
      mode     <= mode_next;
      run      <= run_next;
      out_ctl  <= out_ctl_next;
      prescale <= prescale_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (exec) begin
      out_rdata <= rdata_next;
      out_irq   <= irq_next;
    end
  end

endmodule

>>> design/tcrt_checker.sv
// Port-level checker for the reload timer, attached to the top level by bind.
// Depends on the top level's request and response interface ports.
module tcrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_rdata,
  input logic [2:0]  rsp_irq
);

  // back-pressure only when both the input and result stages are full
  assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (rsp_valid && !rsp_ready))
    else $error("request stalled while response side free");

  // each accepted transaction yields a response after the input and result registers
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> ##1 rsp_valid)
    else $error("response missing two cycles after acceptance");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rdata) && $stable(rsp_irq)))
    else $error("stalled response changed");

  assert property (@(posedge clk)
    rst |=> (!rsp_valid && req_ready))
    else $error("pipeline not empty after reset");

endmodule

bind three_channel_reload_timer tcrt_checker u_tcrt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_rdata (rsp.rdata),
  .rsp_irq   (rsp.irq)
);

>>> dv/tb_three_channel_reload_timer.sv
// Self-checking testbench for the three-channel reload timer.
// Depends on tcrt_pkg, the handshake interfaces in tcrt_if.sv and the timer top level.
// Predicts every response from a local model of the registers, counters and prescaler.
`timescale 1ns / 100ps

module tb_three_channel_reload_timer;
  import tcrt_pkg::*;

  localparam int CH          = CHANNELS_DEFAULT;
  localparam int CYCLE_LIMIT = 300000;

  localparam int KIND_RELOAD  = 0;
  localparam int KIND_COUNT   = 1;
  localparam int KIND_CONTROL = 2;

  localparam logic [3:0] REG_CAPTURE  = 4'(REG_CH_BASE + REGS_PER_CH * CH);
  localparam logic [3:0] REG_UNMAPPED = 4'd15;
  localparam logic [1:0] CMD_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic [31:0]      rdata;
    logic [IRQ_W-1:0] irq;
  } timer_rsp_t;

  logic clk;
  logic rst;

  tcrt_req_if req_if ();
  tcrt_rsp_if rsp_if ();

  three_channel_reload_timer #(.CHANNELS(CH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  logic [31:0]           mdl_count    [CH];
  logic [31:0]           mdl_reload   [CH];
  logic [CTL_W-1:0]      mdl_ctl      [CH];
  logic [2:0]            mdl_div      [CH];
  logic [CH-1:0]         mdl_run;
  logic                  mdl_outctl;
  logic [PRESCALE_W-1:0] mdl_prescale;

  timer_rsp_t pending_responses [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int items_sent;
  int error_count;
  int cycle_count;

  always #4 clk = ~clk;

  function automatic logic [3:0] reg_of(input int ch, input int kind);
    return 4'(REG_CH_BASE + REGS_PER_CH * ch + kind);
  endfunction

  function automatic timer_rsp_t predict_timer_response(input logic [1:0] cmd,
                                                        input logic [3:0] idx,
                                                        input logic [31:0] data);
    timer_rsp_t            result;
    int                    n;
    int                    ch;
    int                    kind;
    int                    shift;
    logic [PRESCALE_W-1:0] low_mask;
    logic [CTL_W-1:0]      ctl_new;
    logic                  in_bank;
    result.rdata = '0;
    result.irq   = '0;
    in_bank = (idx >= REG_CH_BASE) && (idx < REG_CAPTURE);
    ch      = (int'(idx) - REG_CH_BASE) / REGS_PER_CH;
    kind    = (int'(idx) - REG_CH_BASE) % REGS_PER_CH;
    case (cmd)
      CMD_TICK: begin
        mdl_prescale = mdl_prescale + 1'b1;
        for (n = 0; n < CH; n++) begin
          if (mdl_run[n]) begin
            shift = 2 * int'(mdl_div[n]) + 2;
            if (shift > PRESCALE_W) shift = PRESCALE_W;
            low_mask = PRESCALE_W'((32'd1 << shift) - 1);
            if ((mdl_prescale & low_mask) == '0) begin
              if (mdl_count[n] == '0) begin
                mdl_count[n] = mdl_reload[n];
                mdl_ctl[n][UNDERFLOW_BIT] = 1'b1;
              end else begin
                mdl_count[n] = mdl_count[n] - 1;
              end
            end
          end
        end
      end
      CMD_READ: begin
        if (idx == REG_OUT_CTL) begin
          result.rdata = 32'(mdl_outctl);
        end else if (idx == REG_START) begin
          result.rdata = 32'(mdl_run);
        end else if (in_bank) begin
          case (kind)
            KIND_RELOAD: result.rdata = mdl_reload[ch];
            KIND_COUNT:  result.rdata = mdl_count[ch];
            default:     result.rdata = 32'(mdl_ctl[ch]);
          endcase
        end
      end
      CMD_WRITE: begin
        if (idx == REG_OUT_CTL) begin
          mdl_outctl = data[0];
        end else if (idx == REG_START) begin
          mdl_run = data[CH-1:0];
        end else if (in_bank) begin
          case (kind)
            KIND_RELOAD: mdl_reload[ch] = data;
            KIND_COUNT:  mdl_count[ch]  = data;
            default: begin
              ctl_new = data[CTL_W-1:0] & ((ch == CH - 1) ? CTL_MASK_LAST : CTL_MASK_OTHER);
              mdl_ctl[ch] = ctl_new;
              if (ctl_new[2:0] <= MODE_LAST_VALID) mdl_div[ch] = ctl_new[2:0];
            end
          endcase
        end
      end
      default: ;
    endcase
    for (n = 0; n < CH; n++) begin
      if (mdl_ctl[n][UNDERFLOW_BIT] && mdl_ctl[n][ENABLE_BIT]) result.irq[n] = 1'b1;
    end
    return result;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [3:0] idx,
                           input logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= cmd;
    req_if.reg_index <= idx;
    req_if.wdata     <= data;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_responses.push_back(predict_timer_response(cmd, idx, data));
    items_sent++;
  endtask

  task automatic test_register_map();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(CMD_READ, reg_of(0, KIND_RELOAD), '0);
    send_item(CMD_READ, reg_of(0, KIND_COUNT), '0);
    send_item(CMD_READ, reg_of(CH - 1, KIND_CONTROL), '0);
    send_item(CMD_READ, REG_CAPTURE, '1);
    send_item(CMD_READ, REG_UNMAPPED, '1);
    send_item(CMD_WRITE, REG_OUT_CTL, '1);
    send_item(CMD_READ, REG_OUT_CTL, '0);
    send_item(CMD_WRITE, REG_CAPTURE, '1);
    send_item(CMD_READ, REG_CAPTURE, '0);
    send_item(CMD_WRITE, REG_CAPTURE + 4'd1, '1);
    send_item(CMD_UNKNOWN, reg_of(0, KIND_COUNT), '0);
    send_item(CMD_WRITE, reg_of(0, KIND_CONTROL), '1);
    send_item(CMD_READ, reg_of(0, KIND_CONTROL), '0);
    send_item(CMD_WRITE, reg_of(CH - 1, KIND_CONTROL), '1);
    send_item(CMD_READ, reg_of(CH - 1, KIND_CONTROL), '0);
    send_item(CMD_WRITE, reg_of(0, KIND_CONTROL), 32'(1) << ENABLE_BIT);
    send_item(CMD_WRITE, reg_of(0, KIND_RELOAD), '0);
    send_item(CMD_WRITE, reg_of(0, KIND_COUNT), '0);
    send_item(CMD_WRITE, REG_START, '1);
    repeat (4) send_item(CMD_TICK, '0, '0);
    send_item(CMD_READ, reg_of(0, KIND_COUNT), '0);
    send_item(CMD_WRITE, REG_START, '0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
    int          first;
    int          ch;
    logic [31:0] ctl_word;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(99) < 80) begin
        ch = $urandom_range(CH - 1);
        send_item(CMD_WRITE, reg_of(ch, KIND_RELOAD),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(6));
        send_item(CMD_WRITE, reg_of(ch, KIND_COUNT), $urandom_range(5));
        ctl_word = $urandom;
        ctl_word[2:0] = ($urandom_range(5) == 0) ? 3'($urandom_range(7))
                                                 : 3'($urandom_range(1));
        send_item(CMD_WRITE, reg_of(ch, KIND_CONTROL), ctl_word);
        send_item(CMD_WRITE, REG_START, $urandom | (32'd1 << ch));
        repeat ($urandom_range(4, 40)) begin
          if ($urandom_range(9) == 0) send_item(CMD_READ, 4'($urandom_range(15)), $urandom);
          else send_item(CMD_TICK, 4'($urandom_range(15)), $urandom);
        end
        send_item(CMD_READ, reg_of(ch, KIND_CONTROL), $urandom);
        send_item(CMD_READ, reg_of(ch, KIND_COUNT), $urandom);
        if ($urandom_range(1))
          send_item(CMD_WRITE, reg_of(ch, KIND_CONTROL), $urandom & ~(32'd1 << UNDERFLOW_BIT));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom_range(3)), 4'($urandom_range(15)), $urandom);
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left <= 400;
    repeat (30) begin
      if ($urandom_range(1)) send_item(CMD_TICK, '0, '0);
      else send_item(2'($urandom_range(2)), 4'($urandom_range(15)), $urandom);
    end
  endtask

  task automatic test_slow_dividers();
    int ch;
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    for (ch = 0; ch < CH; ch++) begin
      send_item(CMD_WRITE, reg_of(ch, KIND_RELOAD), $urandom_range(3));
      send_item(CMD_WRITE, reg_of(ch, KIND_COUNT), '0);
      send_item(CMD_WRITE, reg_of(ch, KIND_CONTROL),
                (32'd1 << ENABLE_BIT) | 32'(MODE_LAST_VALID - 3'(CH - ch)));
    end
    send_item(CMD_WRITE, REG_START, '1);
    repeat (300) begin
      if ($urandom_range(63) == 0) send_item(CMD_READ, 4'($urandom_range(REG_CAPTURE)), '0);
      else send_item(CMD_TICK, '0, '0);
    end
    for (ch = 0; ch < CH; ch++) send_item(CMD_READ, reg_of(ch, KIND_CONTROL), '0);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    timer_rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_responses.size() == 0) begin
        $error("unexpected response: rdata %h irq %b", rsp_if.rdata, rsp_if.irq);
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        if (rsp_if.rdata !== want.rdata) begin
          $error("rdata mismatch: expected %h, actual %h", want.rdata, rsp_if.rdata);
          error_count++;
        end
        if (rsp_if.irq !== want.irq) begin
          $error("irq mismatch: expected %b, actual %b", want.irq, rsp_if.irq);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** three_channel_reload_timer: FAILED **");
      $finish;
    end
  end

  initial begin
    int n;
    clk              = 1'b0;
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_TICK;
    req_if.reg_index = '0;
    req_if.wdata     = '0;
    rsp_if.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_left        = 0;
    items_sent       = 0;
    error_count      = 0;
    cycle_count      = 0;
    for (n = 0; n < CH; n++) begin
      mdl_count[n]  = '1;
      mdl_reload[n] = '1;
      mdl_ctl[n]    = '0;
      mdl_div[n]    = '0;
    end
    mdl_run      = '0;
    mdl_outctl   = 1'b0;
    mdl_prescale = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_map();
    test_random_traffic(0, 0, 55);
    test_random_traffic(67, 0, 55);
    test_random_traffic(0, 67, 55);
    test_random_traffic(10, 10, 55);
    test_backpressure();
    test_slow_dividers();
    req_if.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_responses.size() == 0) begin
      $display("** three_channel_reload_timer: PASSED **");
    end else begin
      $display("** three_channel_reload_timer: FAILED **");
    end
    $finish;
  end

endmodule
